/* design/lsma_pkg.sv */
// lsma_pkg: types and constants shared by the led strip mode animator
// used by lsma_ctrl, lsma_dpath and led_strip_mode_animator; no dependencies
package lsma_pkg;

  // stream field widths
  localparam int unsigned NowW      = 32;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned PixIdxW   = 6;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 32;

  // configuration port
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  // register reset values
  localparam logic [15:0] RefreshIntervalRst = 16'd60;
  localparam logic [15:0] FlashDurationRst   = 16'd900;
  localparam logic [7:0]  PhaseStepRst       = 8'd4;
  localparam logic [6:0]  ScalePercentRst    = 7'd35;
  localparam logic [7:0]  MessageGreenRst    = 8'd140;

  // wheel segment bounds
  localparam logic [7:0] WheelSeg1 = 8'd85;
  localparam logic [7:0] WheelSeg2 = 8'd170;

  // unscaled channels go through the scaler at one hundred percent
  localparam logic [6:0] FullPercent = 7'd100;
  // floor(x / 100) = (x * DivRecip) >> DivShift for x below 2^15
  localparam logic [15:0] DivRecip = 16'd41944;
  localparam int unsigned DivShift = 22;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_REFRESH_INTERVAL = 3'd0,
    CFG_FLASH_DURATION   = 3'd1,
    CFG_PHASE_STEP       = 3'd2,
    CFG_SCALE_PERCENT    = 3'd3,
    CFG_MESSAGE_GREEN    = 3'd4
  } cfg_idx_e;

  // display modes; MODE_NONE marks no mode seen yet
  typedef enum logic [ModeW-1:0] {
    MODE_IDLE = 2'd0,
    MODE_MSG  = 2'd1,
    MODE_SCAN = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_COLOR,
    ST_MUL,
    ST_LOAD
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic capture;      // take the input item
    logic eval;         // decide on the item, update timing state
    logic color;        // compute raw color of the current pixel
    logic mul;          // channel times percent
    logic load;         // finish scaling, fill output register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic emit;         // item produces a frame
    logic last;         // current pixel is the last of the frame
    logic out_free;     // output register can take a pixel
  } status_t;

endpackage

/* design/lsma_ctrl.sv */
// lsma_ctrl: sequencer of the led strip mode animator
// depends on lsma_pkg; drives lsma_dpath through cmd_t and reads status_t
module lsma_ctrl import lsma_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_tvalid_i,
  output logic    s_tready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = status_i.emit ? ST_COLOR : ST_IDLE;
      end
      ST_COLOR: begin
        cmd_o.color = 1'b1;
        state_d     = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_LOAD;
      end
      ST_LOAD: begin
        // hold until the output register is free
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.last ? ST_IDLE : ST_COLOR;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* design/lsma_dpath.sv */
// lsma_dpath: timing state, configuration, color wheel, scaler and output register
// depends on lsma_pkg; commanded by lsma_ctrl
module lsma_dpath import lsma_pkg::*; #(
  parameter int unsigned PIXELS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  logic                in_func_i,
  input  logic [NowW-1:0]     in_now_i,
  input  logic [ModeW-1:0]    in_mode_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [PixIdxW-1:0]  out_index_o,
  output logic [ChanW-1:0]    out_red_o,
  output logic [ChanW-1:0]    out_green_o,
  output logic [ChanW-1:0]    out_blue_o,
  output logic                out_last_o
);

  // per pixel wheel position step: floor(i*256/PIXELS) by quotient and remainder
  localparam int unsigned PosStep = 256 / PIXELS;
  localparam int unsigned PosRem  = 256 % PIXELS;

  // configuration registers
  logic [15:0] refresh_ivl_q;
  logic [15:0] flash_dur_q;
  logic [7:0]  phase_step_q;
  logic [6:0]  scale_pct_q;
  logic [7:0]  msg_green_q;

  // captured item
  logic             func_q;
  logic [NowW-1:0]  now_q;
  mode_e            mode_q;

  // timing state
  logic [NowW-1:0]  flash_end_q;
  logic [NowW-1:0]  last_refresh_q;
  mode_e            prev_mode_q;
  logic [7:0]       phase_q;
  mode_e            kind_q;

  // pixel walk
  logic [PixIdxW-1:0] idx_q;
  logic [7:0]         pos_base_q;
  logic [PixIdxW-1:0] pos_rem_q;

  // color pipeline
  logic [ChanW-1:0] r_q, g_q, b_q;
  logic [14:0]      pr_q, pg_q, pb_q;
  logic             m_tvalid_q;
  logic [PixIdxW-1:0] o_idx_q;
  logic [ChanW-1:0] o_r_q, o_g_q, o_b_q;
  logic             o_last_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refresh_ivl_q <= RefreshIntervalRst;
      flash_dur_q   <= FlashDurationRst;
      phase_step_q  <= PhaseStepRst;
      scale_pct_q   <= ScalePercentRst;
      msg_green_q   <= MessageGreenRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_REFRESH_INTERVAL: refresh_ivl_q <= cfg_data_i;
        CFG_FLASH_DURATION:   flash_dur_q   <= cfg_data_i;
        CFG_PHASE_STEP:       phase_step_q  <= cfg_data_i[7:0];
        CFG_SCALE_PERCENT:    scale_pct_q   <= cfg_data_i[6:0];
        CFG_MESSAGE_GREEN:    msg_green_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= in_func_i;
      now_q  <= in_now_i;
      mode_q <= mode_e'(in_mode_i);
    end
  end

  // event decision
  mode_e            req_mode;
  mode_e            eff_mode;
  logic             flash_open;
  logic             flash_armed;
  logic [NowW-1:0]  elapsed;
  logic             too_soon;

  always_comb begin
    req_mode    = (mode_q == MODE_NONE) ? MODE_SCAN : mode_q;
    flash_armed = (flash_end_q != '0);
    flash_open  = flash_armed && (now_q < flash_end_q);
    eff_mode    = flash_open ? MODE_MSG : req_mode;
    elapsed     = now_q - last_refresh_q;
    too_soon    = elapsed < {16'd0, refresh_ivl_q};
    if (func_q) begin
      status_o.emit = 1'b0;
    end else if (eff_mode == MODE_IDLE) begin
      status_o.emit = (prev_mode_q != MODE_IDLE);
    end else begin
      status_o.emit = !too_soon;
    end
  end

  // timing state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_end_q    <= '0;
      last_refresh_q <= '0;
      prev_mode_q    <= MODE_NONE;
      phase_q        <= '0;
      kind_q         <= MODE_IDLE;
    end else if (cmd_i.eval) begin
      if (func_q) begin
        flash_end_q <= now_q + {16'd0, flash_dur_q};
      end else begin
        if (flash_armed && !flash_open) begin
          flash_end_q <= '0;
        end
        prev_mode_q <= eff_mode;
        kind_q      <= eff_mode;
        if (eff_mode != MODE_IDLE && !too_soon) begin
          last_refresh_q <= now_q;
          if (eff_mode == MODE_SCAN) begin
            phase_q <= phase_q + phase_step_q;
          end
        end
      end
    end
  end

  // pixel walk: index and wheel base position
  logic [PixIdxW:0]   rem_sum;
  logic               rem_carry;
  logic [PixIdxW-1:0] rem_next;

  always_comb begin
    rem_sum   = {1'b0, pos_rem_q} + (PixIdxW+1)'(PosRem);
    rem_carry = rem_sum >= (PixIdxW+1)'(PIXELS);
    rem_next  = rem_carry ? PixIdxW'(rem_sum - (PixIdxW+1)'(PIXELS)) : rem_sum[PixIdxW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      idx_q      <= '0;
      pos_base_q <= '0;
      pos_rem_q  <= '0;
    end else if (cmd_i.load) begin
      idx_q      <= idx_q + 1'b1;
      pos_base_q <= pos_base_q + 8'(PosStep) + {7'd0, rem_carry};
      pos_rem_q  <= rem_next;
    end
  end

  assign status_o.last = (idx_q == PixIdxW'(PIXELS - 1));

  // color wheel
  logic [7:0] wp;
  logic [7:0] wq;
  logic [8:0] w3;
  logic [ChanW-1:0] wr, wg, wb;

  always_comb begin
    wp = ~(pos_base_q + phase_q);
    priority if (wp < WheelSeg1) begin
      wq = wp;
    end else if (wp < WheelSeg2) begin
      wq = wp - WheelSeg1;
    end else begin
      wq = wp - WheelSeg2;
    end
    w3 = {1'b0, wq} + {wq, 1'b0};
    priority if (wp < WheelSeg1) begin
      wr = 8'd255 - w3[7:0];
      wg = '0;
      wb = w3[7:0];
    end else if (wp < WheelSeg2) begin
      wr = '0;
      wg = w3[7:0];
      wb = 8'd255 - w3[7:0];
    end else begin
      wr = w3[7:0];
      wg = 8'd255 - w3[7:0];
      wb = '0;
    end
  end

  // raw color by frame kind
  always_ff @(posedge clk_i) begin
    if (cmd_i.color) begin
      unique case (kind_q)
        MODE_SCAN, MODE_NONE: begin
          r_q <= wr;
          g_q <= wg;
          b_q <= wb;
        end
        MODE_MSG: begin
          r_q <= '0;
          g_q <= msg_green_q;
          b_q <= '0;
        end
        default: begin
          r_q <= '0;
          g_q <= '0;
          b_q <= '0;
        end
      endcase
    end
  end

  // channel times percent; other frames pass at one hundred percent
  logic [6:0] pct_sel;
  assign pct_sel = (kind_q == MODE_SCAN) ? scale_pct_q : FullPercent;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      pr_q <= r_q * pct_sel;
      pg_q <= g_q * pct_sel;
      pb_q <= b_q * pct_sel;
    end
  end

  // divide by one hundred through the reciprocal, saturate
  function automatic logic [ChanW-1:0] div100_sat(input logic [14:0] x);
    logic [30:0] m;
    logic [8:0]  qv;
    m  = x * DivRecip;
    qv = m[30:DivShift];
    return qv[8] ? 8'd255 : qv[7:0];
  endfunction

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (cmd_i.load) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      o_idx_q  <= idx_q;
      o_r_q    <= div100_sat(pr_q);
      o_g_q    <= div100_sat(pg_q);
      o_b_q    <= div100_sat(pb_q);
      o_last_q <= status_o.last;
    end
  end

  assign status_o.out_free = !m_tvalid_q || m_tready_i;
  assign m_tvalid_o  = m_tvalid_q;
  assign out_index_o = o_idx_q;
  assign out_red_o   = o_r_q;
  assign out_green_o = o_g_q;
  assign out_blue_o  = o_b_q;
  assign out_last_o  = o_last_q;

endmodule

/* design/led_strip_mode_animator.sv */
// led_strip_mode_animator: top level, timed led strip animator
// depends on lsma_pkg, lsma_ctrl and lsma_dpath
//
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   tdata: now_ms, mode_req; tuser: func
// m_*       out  m_tvalid/m_tready   tdata: pixel_index, red, green, blue; tlast
// cfg_*     in   cfg_we_i            cfg_idx_i, cfg_data_i
//
// an item is taken in one cycle and judged in the next; an item that emits no
// frame returns the controller to idle once it is judged
// a frame passes each pixel through the color, multiply and scale steps of
// one shared color unit
// the last pixel waits in the output register while the next item is taken
// a stalled output holds the pixel walk at the scale step
// reset clears the timing state and loads the register defaults
module led_strip_mode_animator import lsma_pkg::*; #(
  parameter int unsigned PIXELS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  logic [InDataW-1:0]  s_tdata_i,   // now_ms[31:0], mode_req[33:32], zeros
  input  logic                s_tuser_i,   // func
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [OutDataW-1:0] m_tdata_o,   // pixel_index, red, green, blue, zeros
  output logic                m_tlast_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  logic [PixIdxW-1:0] out_index;
  logic [ChanW-1:0]   out_red, out_green, out_blue;

  lsma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lsma_dpath #(
    .PIXELS (PIXELS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_func_i   (s_tuser_i),
    .in_now_i    (s_tdata_i[NowW-1:0]),
    .in_mode_i   (s_tdata_i[NowW+ModeW-1:NowW]),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .out_index_o (out_index),
    .out_red_o   (out_red),
    .out_green_o (out_green),
    .out_blue_o  (out_blue),
    .out_last_o  (m_tlast_o)
  );

  // pack output item
  assign m_tdata_o = {2'b00, out_blue, out_green, out_red, out_index};

  // no second item is taken in the cycle after one is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("input taken while previous item is judged");

  // the frame end marker sits on the last pixel only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tlast_o |-> m_tdata_o[PixIdxW-1:0] == PixIdxW'(PIXELS - 1))
    else $error("frame end on wrong pixel");

  // mid frame no new input is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load && !status.last |=> !s_tready_o)
    else $error("input accepted inside a frame");

  // a pixel is only loaded into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> !m_tvalid_o || m_tready_i)
    else $error("output pixel overwritten");

endmodule
